FILE: rtl/rlsm_pkg.sv
// Shared types, constants and helpers for the RGB luma Sobel magnitude block.
// No dependencies; every other file in rtl/ except rlsm_ram imports this package.
package rlsm_pkg;

   // Default line length; the port parameter takes its default from here
   localparam int MAX_WIDTH_DEFAULT = 256;

   // Column indexes are carried at a fixed width that covers the largest line
   localparam int COL_BITS = 13;

   // Job queue between the front and the back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;
   localparam int QCNT_BITS   = 3;

   // Luma weights, 8-bit fixed point with round to nearest
   localparam logic [7:0]  LUMA_R     = 8'd77;
   localparam logic [7:0]  LUMA_G     = 8'd151;
   localparam logic [7:0]  LUMA_B     = 8'd28;
   localparam logic [15:0] LUMA_ROUND = 16'd128;

   // Square root: radicand below 2^21, first trial bit is 4^10
   localparam int SQ_BITS = 21;
   localparam logic [SQ_BITS-1:0] ROOT_FIRST_BIT = 21'h100000;

   typedef logic [1:0]          slot_type;
   typedef logic [COL_BITS-1:0] col_type;

   // One Sobel evaluation handed from front to back
   typedef struct packed {
      slot_type top;
      slot_type mid;
      slot_type bot;
      col_type  xl;
      col_type  x;
      col_type  xr;
      logic     row_end;
      logic     frame_end;
   } job_type;

   // What the front adds to the queue in one cycle (zero, one or two jobs)
   typedef struct packed {
      logic [1:0] count;
      job_type    first;
      job_type    second;
   } push_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_GRAD,
      ST_SQUARE,
      ST_ROOT,
      ST_OUT
   } back_state_type;

   // Slot arithmetic modulo three
   function automatic slot_type slot_next(input slot_type s);
      slot_next = (s == 2'd2) ? 2'd0 : s + 2'd1;
   endfunction

   function automatic slot_type slot_prev(input slot_type s);
      slot_prev = (s == 2'd0) ? 2'd2 : s - 2'd1;
   endfunction

endpackage

FILE: rtl/rlsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module rlsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rlsm_front.sv
// Front end: accepts pixel and drain items, converts to luma, writes the line
// store and queues Sobel jobs. Depends on rlsm_pkg.
module rlsm_front import rlsm_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [8:0]                       frame_width,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_operation,
   input  logic [7:0]                       req_red,
   input  logic [7:0]                       req_green,
   input  logic [7:0]                       req_blue,
   input  logic                             req_frame_start,
   input  logic [QCNT_BITS-1:0]             queue_count,
   input  logic                             back_busy,
   output logic                             wr_en,
   output logic [$clog2(3*MAX_WIDTH)-1:0]   wr_addr,
   output logic [7:0]                       wr_data,
   output push_type                         push
);

   localparam int AW = $clog2(3*MAX_WIDTH);

   col_type  column_ff, column_in;
   col_type  drain_ff,  drain_in;
   logic [1:0] rows_ff, rows_in;
   slot_type rotate_ff, rotate_in;

   col_type  width_eff;
   col_type  last_col;
   col_type  col_start;
   col_type  col;
   logic [1:0] rows_start;
   slot_type cur;
   slot_type mid;
   slot_type top;
   logic     accept;
   logic     first_col;
   logic     pending;
   logic [15:0] luma_sum;
   job_type  job_a;
   job_type  job_b;

   // Effective width: zero acts as one, clipped to the line store
   always_comb begin
      priority if (frame_width == 9'd0) begin
         width_eff = col_type'(1);
      end else if (COL_BITS'(frame_width) > col_type'(MAX_WIDTH)) begin
         width_eff = col_type'(MAX_WIDTH);
      end else begin
         width_eff = COL_BITS'(frame_width);
      end
   end
   assign last_col = width_eff - col_type'(1);

   // Counters as seen by this pixel, after a frame start
   assign col_start  = req_frame_start ? '0 : column_ff;
   assign rows_start = req_frame_start ? 2'd0 : rows_ff;
   assign cur        = req_frame_start ? 2'd0 : rotate_ff;
   assign col        = (col_start < width_eff) ? col_start : last_col;
   assign mid        = slot_prev(cur);
   assign top        = (rows_start == 2'd2) ? slot_next(cur) : mid;

   // A new row overwrites a slot that queued jobs may still read
   assign first_col = req_frame_start || (column_ff == '0);
   assign pending   = (queue_count != '0) || back_busy;
   assign req_stall = (queue_count > QCNT_BITS'(QUEUE_DEPTH - 2))
                      || (!req_operation && first_col && pending);
   assign accept    = req_valid && !req_stall;

   // Luma conversion
   assign luma_sum = 16'(LUMA_R) * 16'(req_red) + 16'(LUMA_G) * 16'(req_green)
                   + 16'(LUMA_B) * 16'(req_blue) + LUMA_ROUND;

   assign wr_en   = accept && !req_operation;
   assign wr_addr = AW'(cur) * AW'(MAX_WIDTH) + AW'(col);
   assign wr_data = luma_sum[15:8];

   // Job building
   always_comb begin
      job_a = '0;
      job_b = '0;
      push  = '0;
      if (req_operation) begin
         // drain: bottom row replicated from the middle row
         job_a.mid       = slot_prev(rotate_ff);
         job_a.top       = (rows_ff == 2'd2) ? slot_next(rotate_ff)
                                             : slot_prev(rotate_ff);
         job_a.bot       = slot_prev(rotate_ff);
         job_a.x         = drain_ff;
         job_a.xl        = (drain_ff != '0) ? drain_ff - col_type'(1) : '0;
         job_a.xr        = (drain_ff < last_col) ? drain_ff + col_type'(1) : last_col;
         job_a.row_end   = (drain_ff == last_col);
         job_a.frame_end = (drain_ff == last_col);
         if (accept && (rows_ff != 2'd0) && (drain_ff < width_eff)) begin
            push.count = 2'd1;
         end
      end else begin
         // column behind the input
         job_a.top     = top;
         job_a.mid     = mid;
         job_a.bot     = cur;
         job_a.x       = col - col_type'(1);
         job_a.xl      = (col > col_type'(1)) ? col - col_type'(2) : '0;
         job_a.xr      = col;
         job_a.row_end = 1'b0;
         // last column of the row
         job_b.top     = top;
         job_b.mid     = mid;
         job_b.bot     = cur;
         job_b.x       = col;
         job_b.xl      = (col != '0) ? col - col_type'(1) : '0;
         job_b.xr      = col;
         job_b.row_end = 1'b1;
         if (accept && (rows_start != 2'd0)) begin
            priority if ((col != '0) && (col == last_col)) begin
               push.count = 2'd2;
            end else if (col != '0) begin
               push.count = 2'd1;
            end else if (col == last_col) begin
               push.count = 2'd1;
               job_a      = job_b;
            end else begin
               push.count = 2'd0;
            end
         end
      end
      push.first  = job_a;
      push.second = job_b;
   end

   // Counter updates
   always_comb begin
      column_in = column_ff;
      drain_in  = drain_ff;
      rows_in   = rows_ff;
      rotate_in = rotate_ff;
      if (accept) begin
         if (req_operation) begin
            if ((rows_ff != 2'd0) && (drain_ff < width_eff)) begin
               drain_in = drain_ff + col_type'(1);
            end
         end else begin
            drain_in = '0;
            if (col == last_col) begin
               column_in = '0;
               rotate_in = slot_next(cur);
               rows_in   = (rows_start == 2'd2) ? 2'd2 : rows_start + 2'd1;
            end else begin
               column_in = col + col_type'(1);
               rotate_in = cur;
               rows_in   = rows_start;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         drain_ff  <= '0;
         rows_ff   <= 2'd0;
         rotate_ff <= 2'd0;
      end else begin
         column_ff <= column_in;
         drain_ff  <= drain_in;
         rows_ff   <= rows_in;
         rotate_ff <= rotate_in;
      end
   end

endmodule

FILE: rtl/rlsm_queue.sv
// Job queue between front and back: up to two pushes and one pop per cycle.
// Depends on rlsm_pkg.
module rlsm_queue import rlsm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  push_type             push,
   input  logic                 pop,
   output job_type              head,
   output logic                 head_valid,
   output logic [QCNT_BITS-1:0] count
);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff,  count_in;
   logic                   do_pop;

   assign do_pop     = pop && (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign count      = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + QPTR_BITS'(do_pop);
      count_in  = count_ff + QCNT_BITS'(push.count) - QCNT_BITS'(do_pop);
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + QPTR_BITS'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/rlsm_back.sv
// Back end: reads the 3x3 window from the line store, forms the Sobel
// gradients and an iterative integer square root. Depends on rlsm_pkg.
module rlsm_back import rlsm_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  job_type                        head,
   input  logic                           head_valid,
   output logic                           pop,
   output logic                           busy,
   output logic                           rd_en,
   output logic [$clog2(3*MAX_WIDTH)-1:0] rd_addr,
   input  logic [7:0]                     rd_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [10:0]                    rsp_magnitude,
   output logic signed [10:0]             rsp_grad_x,
   output logic signed [10:0]             rsp_grad_y,
   output logic                           rsp_row_end,
   output logic                           rsp_frame_end
);

   localparam int AW = $clog2(3*MAX_WIDTH);

   back_state_type state_ff, state_in;
   job_type             job_ff;
   logic [3:0]          step_ff;
   logic [7:0]          px_ff [8];
   logic signed [10:0]  gx_ff;
   logic signed [10:0]  gy_ff;
   logic [SQ_BITS-1:0]  v_ff;
   logic [SQ_BITS:0]    root_ff;
   logic [SQ_BITS-1:0]  bit_ff;

   slot_type            tap_slot;
   col_type             tap_col;
   logic signed [10:0]  sum_l, sum_r, sum_t, sum_b;
   logic signed [21:0]  sq_x, sq_y;
   logic [SQ_BITS:0]    trial;

   // Window tap order: top l/m/r, mid l/r, bottom l/m/r
   always_comb begin
      unique case (step_ff[2:0])
         3'd0: begin tap_slot = job_ff.top; tap_col = job_ff.xl; end
         3'd1: begin tap_slot = job_ff.top; tap_col = job_ff.x;  end
         3'd2: begin tap_slot = job_ff.top; tap_col = job_ff.xr; end
         3'd3: begin tap_slot = job_ff.mid; tap_col = job_ff.xl; end
         3'd4: begin tap_slot = job_ff.mid; tap_col = job_ff.xr; end
         3'd5: begin tap_slot = job_ff.bot; tap_col = job_ff.xl; end
         3'd6: begin tap_slot = job_ff.bot; tap_col = job_ff.x;  end
         default: begin tap_slot = job_ff.bot; tap_col = job_ff.xr; end
      endcase
   end
   assign rd_addr = AW'(tap_slot) * AW'(MAX_WIDTH) + AW'(tap_col);

   // Column and row sums of the window
   assign sum_l = 11'(px_ff[0]) + 11'({px_ff[3], 1'b0}) + 11'(px_ff[5]);
   assign sum_r = 11'(px_ff[2]) + 11'({px_ff[4], 1'b0}) + 11'(px_ff[7]);
   assign sum_t = 11'(px_ff[0]) + 11'({px_ff[1], 1'b0}) + 11'(px_ff[2]);
   assign sum_b = 11'(px_ff[5]) + 11'({px_ff[6], 1'b0}) + 11'(px_ff[7]);

   assign sq_x  = gx_ff * gx_ff;
   assign sq_y  = gy_ff * gy_ff;
   assign trial = root_ff + (SQ_BITS+1)'(bit_ff);

   // Next state and control
   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      rd_en    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop      = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_en = (step_ff < 4'd8);
            if (step_ff == 4'd8) begin
               state_in = ST_GRAD;
            end
         end
         ST_GRAD:   state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_ROOT;
         ST_ROOT: begin
            if (bit_ff == SQ_BITS'(1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            job_ff  <= head;
            step_ff <= 4'd0;
         end
         ST_READ: begin
            step_ff <= step_ff + 4'd1;
            if (step_ff != 4'd0) begin
               px_ff[step_ff[2:0] - 3'd1] <= rd_data;
            end
         end
         ST_GRAD: begin
            gx_ff <= sum_r - sum_l;
            gy_ff <= sum_b - sum_t;
         end
         ST_SQUARE: begin
            v_ff    <= sq_x[SQ_BITS-1:0] + sq_y[SQ_BITS-1:0];
            root_ff <= '0;
            bit_ff  <= ROOT_FIRST_BIT;
         end
         ST_ROOT: begin
            if ((SQ_BITS+1)'(v_ff) >= trial) begin
               v_ff    <= v_ff - trial[SQ_BITS-1:0];
               root_ff <= (root_ff >> 1) + (SQ_BITS+1)'(bit_ff);
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         default: begin
         end
      endcase
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = (state_ff == ST_OUT);
   assign rsp_magnitude = root_ff[10:0];
   assign rsp_grad_x    = gx_ff;
   assign rsp_grad_y    = gy_ff;
   assign rsp_row_end   = job_ff.row_end;
   assign rsp_frame_end = job_ff.frame_end;

endmodule

FILE: rtl/rgb_luma_sobel_magnitude.sv
// Top level of the RGB luma Sobel magnitude block: configuration register,
// front, job queue, back and line store. Depends on rlsm_pkg and all rlsm_*.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   operation, red, green, blue, frame_start
//   rsp      out        rsp_valid / rsp_stall   magnitude, grad_x, grad_y, row_end, frame_end
//   csr      in         psel/penable/pready     frame_width at byte address 0
//
// The back end works on one job at a time: it takes the job, makes eight line
// store reads on its single read port with registered read data, forms the
// gradient, squares, runs eleven square root iterations and holds the output
// while rsp_stall is high. The front takes items while the queue has room for two
// jobs; the first pixel of a row waits until queued jobs are finished.
// Reset is synchronous; the line store needs no clearing.
module rgb_luma_sobel_magnitude import rlsm_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [7:0]         req_red,
   input  logic [7:0]         req_green,
   input  logic [7:0]         req_blue,
   input  logic               req_frame_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [10:0]        rsp_magnitude,
   output logic signed [10:0] rsp_grad_x,
   output logic signed [10:0] rsp_grad_y,
   output logic               rsp_row_end,
   output logic               rsp_frame_end,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [1:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int AW = $clog2(3*MAX_WIDTH);

   logic [8:0]           frame_width_ff, frame_width_in;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [7:0]           wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [7:0]           rd_data;
   push_type             push;
   job_type              head;
   logic                 head_valid;
   logic                 pop;
   logic                 back_busy;
   logic [QCNT_BITS-1:0] queue_count;

   // Configuration register
   assign pready = 1'b1;
   assign prdata = {23'd0, frame_width_ff};
   assign frame_width_in = (psel && penable && pwrite && (paddr == 2'd0))
                           ? pwdata[8:0] : frame_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= 9'd256;
      end else begin
         frame_width_ff <= frame_width_in;
      end
   end

   rlsm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock           (clock),
      .reset           (reset),
      .frame_width     (frame_width_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_frame_start (req_frame_start),
      .queue_count     (queue_count),
      .back_busy       (back_busy),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .push            (push)
   );

   rlsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .count      (queue_count)
   );

   // Three line stores in one memory
   rlsm_ram #(.WIDTH(8), .DEPTH(3*MAX_WIDTH)) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rlsm_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .head_valid    (head_valid),
      .pop           (pop),
      .busy          (back_busy),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_magnitude (rsp_magnitude),
      .rsp_grad_x    (rsp_grad_x),
      .rsp_grad_y    (rsp_grad_y),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for rgb_luma_sobel_magnitude: random raster frames, drains and
// frame_width changes, results checked against a built-in luma/Sobel predictor.
// Depends on rtl/rlsm_pkg.sv and the RTL of the block.
module testbench;
   import rlsm_pkg::*;

   localparam int LINE_MAX = 256;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      bit       op;
      bit [7:0] red;
      bit [7:0] green;
      bit [7:0] blue;
      bit       fstart;
   } pixel_item_type;

   typedef struct packed {
      logic [10:0]        mag;
      logic signed [10:0] gx;
      logic signed [10:0] gy;
      logic               row_end;
      logic               frame_end;
   } gradient_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_operation = 1'b0;
   logic [7:0]         req_red = '0;
   logic [7:0]         req_green = '0;
   logic [7:0]         req_blue = '0;
   logic               req_frame_start = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [10:0]        rsp_magnitude;
   logic signed [10:0] rsp_grad_x;
   logic signed [10:0] rsp_grad_y;
   logic               rsp_row_end;
   logic               rsp_frame_end;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [1:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   rgb_luma_sobel_magnitude i_dut (.*);

   always #5 clock = ~clock;

   // Predictor state
   bit [7:0]  luma_rows [3][LINE_MAX];
   int        col_pos;
   int        rows_done;
   int        cur_slot;
   int        drained;
   bit [8:0]  width_reg = 9'd256;

   pixel_item_type feed_q [$];
   gradient_type   gradient_q [$];
   int             issued;
   bit             failed;
   bit             calm;
   bit             req_fire;
   int             req_gap;
   int             stall_left;
   int             quiet_cycles;

   function automatic int usable_width(input int w);
      if (w == 0) return 1;
      if (w > LINE_MAX) return LINE_MAX;
      return w;
   endfunction

   function automatic int int_root(input int sq);
      int root;
      root = 0;
      for (int b = 10; b >= 0; b--)
         if ((root | (1 << b)) * (root | (1 << b)) <= sq) root = root | (1 << b);
      return root;
   endfunction

   // 3x3 Sobel around column x, borders replicated
   function automatic gradient_type sobel(input int top, input int mid, input int bot,
                                          input int x, input int w, input bit fend);
      gradient_type g;
      int xl, xr, gx, gy;
      xl = (x > 0) ? x - 1 : 0;
      xr = (x + 1 < w) ? x + 1 : w - 1;
      gx = (luma_rows[top][xr] + 2 * luma_rows[mid][xr] + luma_rows[bot][xr])
         - (luma_rows[top][xl] + 2 * luma_rows[mid][xl] + luma_rows[bot][xl]);
      gy = (luma_rows[bot][xl] + 2 * luma_rows[bot][x] + luma_rows[bot][xr])
         - (luma_rows[top][xl] + 2 * luma_rows[top][x] + luma_rows[top][xr]);
      g.mag = 11'(int_root(gx * gx + gy * gy));
      g.gx = 11'(gx);
      g.gy = 11'(gy);
      g.row_end = (x == w - 1);
      g.frame_end = fend;
      return g;
   endfunction

   // Advance the predictor by one accepted item and queue its results
   function automatic void predict_gradients(input pixel_item_type it);
      int w, c, mid, top, luma;
      w = usable_width(width_reg);
      if (it.op) begin
         if (rows_done == 0 || drained >= w) return;
         mid = (cur_slot + 2) % 3;
         top = (rows_done >= 2) ? (cur_slot + 1) % 3 : mid;
         gradient_q.push_back(sobel(top, mid, mid, drained, w, drained == w - 1));
         drained++;
         return;
      end
      if (it.fstart) begin
         col_pos = 0;
         rows_done = 0;
         cur_slot = 0;
      end
      drained = 0;
      luma = (77 * it.red + 151 * it.green + 28 * it.blue + 128) >> 8;
      c = (col_pos < w) ? col_pos : w - 1;
      luma_rows[cur_slot][c] = 8'(luma);
      if (rows_done >= 1) begin
         mid = (cur_slot + 2) % 3;
         top = (rows_done >= 2) ? (cur_slot + 1) % 3 : mid;
         if (c >= 1) gradient_q.push_back(sobel(top, mid, cur_slot, c - 1, w, 1'b0));
         if (c == w - 1) gradient_q.push_back(sobel(top, mid, cur_slot, c, w, 1'b0));
      end
      if (c == w - 1) begin
         col_pos = 0;
         cur_slot = (cur_slot + 1) % 3;
         if (rows_done < 2) rows_done++;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Input driver: new item or bubble at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_fire) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (feed_q.size() > 0) begin
               req_valid <= 1'b1;
               req_operation <= feed_q[0].op;
               req_red <= feed_q[0].red;
               req_green <= feed_q[0].green;
               req_blue <= feed_q[0].blue;
               req_frame_start <= feed_q[0].fstart;
               void'(feed_q.pop_front());
               req_gap <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
         // result back-pressure
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left <= pick_gap();
         end
      end
   end

   // Monitor: predict on accepted items, check accepted results
   always @(posedge clock) begin
      gradient_type want;
      pixel_item_type it;
      bit in_fire;
      bit out_fire;
      in_fire = !reset && req_valid && !req_stall;
      out_fire = !reset && rsp_valid && !rsp_stall;
      req_fire <= in_fire;
      if (!reset) begin
         quiet_cycles <= (in_fire || out_fire) ? 0 : quiet_cycles + 1;
         if (in_fire) begin
            it.op = req_operation;
            it.red = req_red;
            it.green = req_green;
            it.blue = req_blue;
            it.fstart = req_frame_start;
            predict_gradients(it);
         end
         if (out_fire) begin
            if (gradient_q.size() == 0) begin
               $display("%0t: unexpected result mag=%0d gx=%0d gy=%0d", $time,
                        rsp_magnitude, rsp_grad_x, rsp_grad_y);
               failed = 1'b1;
            end else begin
               want = gradient_q.pop_front();
               if (rsp_magnitude !== want.mag || rsp_grad_x !== want.gx ||
                   rsp_grad_y !== want.gy || rsp_row_end !== want.row_end ||
                   rsp_frame_end !== want.frame_end) begin
                  $display("%0t: mismatch expected mag=%0d gx=%0d gy=%0d re=%0b fe=%0b",
                           $time, want.mag, want.gx, want.gy, want.row_end,
                           want.frame_end);
                  $display("%0t:          actual   mag=%0d gx=%0d gy=%0d re=%0b fe=%0b",
                           $time, rsp_magnitude, rsp_grad_x, rsp_grad_y, rsp_row_end,
                           rsp_frame_end);
                  failed = 1'b1;
               end
            end
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("rgb_luma_sobel_magnitude test failed");
            $finish;
         end
      end
   end

   task automatic add_item(input bit op, input bit [7:0] r, input bit [7:0] g,
                           input bit [7:0] b, input bit fs);
      pixel_item_type it;
      it.op = op;
      it.red = r;
      it.green = g;
      it.blue = b;
      it.fstart = fs;
      feed_q.push_back(it);
      issued++;
   endtask

   task automatic add_pixel(input bit fs);
      add_item(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), fs);
   endtask

   task automatic add_drain();
      add_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
   endtask

   // Sender holds off until every expected result is back and the block settles
   task automatic wait_idle();
      while (feed_q.size() > 0 || req_valid || gradient_q.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Setup cycle, then access cycle
   task automatic write_width(input int w);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= 2'd0;
      pwdata <= 32'(w);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      width_reg = 9'(w);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   initial begin
      int w, ew, rows, part, ndrain, choice, loops;
      bit need_fs, big_done;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: drain with no completed row
      add_item(1'b1, 8'd0, 8'd0, 8'd0, 1'b1);
      wait_idle();
      // directed: 3x3 frame with color extremes, then drains past the row end
      write_width(3);
      add_item(1'b0, 8'd0, 8'd0, 8'd0, 1'b1);
      add_item(1'b0, 8'd255, 8'd255, 8'd255, 1'b0);
      add_item(1'b0, 8'd255, 8'd0, 8'd0, 1'b0);
      add_item(1'b0, 8'd0, 8'd255, 8'd0, 1'b0);
      add_item(1'b0, 8'd0, 8'd0, 8'd255, 1'b0);
      add_item(1'b0, 8'd255, 8'd255, 8'd255, 1'b0);
      add_item(1'b0, 8'd255, 8'd255, 8'd255, 1'b0);
      add_item(1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
      add_item(1'b0, 8'd128, 8'd1, 8'd254, 1'b0);
      repeat (4) add_drain();
      wait_idle();
      // directed: width shrinks mid-row, column past width is taken as last
      write_width(4);
      add_pixel(1'b1);
      repeat (5) add_pixel(1'b0);
      wait_idle();
      write_width(2);
      repeat (3) add_pixel(1'b0);
      repeat (3) add_drain();
      wait_idle();

      // random frames at changing widths; one frame at the full line length
      big_done = 1'b0;
      while (issued < 1150) begin
         choice = $urandom_range(0, 19);
         if (choice == 0) w = 0;
         else if (choice == 1) w = 1;
         else w = $urandom_range(2, 24);
         if (!big_done && issued > 300)
            w = ($urandom_range(0, 1) == 0) ? 256 : $urandom_range(257, 511);
         ew = usable_width(w);
         if (ew == LINE_MAX) big_done = 1'b1;
         write_width(w);
         need_fs = 1'b1;
         calm = ($urandom_range(0, 3) == 0);
         loops = (ew > 32) ? 1 : $urandom_range(1, 3);
         repeat (loops) begin
            rows = (ew > 32) ? 2 : $urandom_range(1, 4);
            for (int r = 0; r < rows; r++)
               for (int c = 0; c < ew; c++) begin
                  add_pixel(r == 0 && c == 0 && (need_fs || $urandom_range(0, 3) != 0));
                  if ($urandom_range(0, 19) == 0) add_drain();
               end
            part = (ew > 1 && ew <= 32 && $urandom_range(0, 3) == 0)
                   ? $urandom_range(1, ew - 1) : 0;
            repeat (part) add_pixel(1'b0);
            need_fs = (part > 0);
            ndrain = (ew > 32) ? ew + 1 : $urandom_range(0, ew + 2);
            repeat (ndrain) add_drain();
         end
         wait_idle();
      end
      calm = 1'b0;
      wait_idle();
      if (!failed)
         $display("rgb_luma_sobel_magnitude test passed");
      else
         $display("rgb_luma_sobel_magnitude test failed");
      $finish;
   end

endmodule

FILE: rgb_luma_sobel_magnitude.f
rtl/rlsm_pkg.sv
rtl/rlsm_ram.sv
rtl/rlsm_front.sv
rtl/rlsm_queue.sv
rtl/rlsm_back.sv
rtl/rgb_luma_sobel_magnitude.sv
verif/testbench.sv
